// File: rtl/core/bpc_pkg.sv
package bpc_pkg;

	localparam logic [7:0] RegCalTemp   = 8'd0;
	localparam logic [7:0] RegCalPressA = 8'd1;
	localparam logic [7:0] RegCalPressB = 8'd2;
	localparam logic [7:0] RegCalPressC = 8'd3;

	localparam logic signed [31:0] OffsetFine = 32'sd128000;
	localparam logic [63:0]        ScaleDiv   = 64'd3125;
	localparam logic [20:0]        PressFull  = 21'd1048576;
	localparam int                 ShiftOne   = 47;
	localparam int                 ShiftDiv   = 33;
	localparam logic signed [34:0] RoundT     = 35'sd128;
	localparam int                 DivSteps   = 64;

	typedef struct packed {
		logic signed [31:0] fine_temp;
		logic signed [31:0] temp_centi;
		logic               bad;
		logic               neg;
	} bpc_side_t;

	// low 64 bits of a 64-bit word times a signed 17-bit coefficient
	function automatic logic [63:0] mul64x16(input logic [63:0] x,
		input logic signed [16:0] c);
		logic signed [80:0] prod;
		prod = $signed(x) * c;
		return prod[63:0];
	endfunction

endpackage

// File: rtl/core/bpc_in_if.sv
interface bpc_in_if;
	logic        valid;
	logic        ready;
	logic [19:0] adc_temp;
	logic [19:0] adc_press;

	modport source(output valid, output adc_temp, output adc_press, input ready);
	modport sink(input valid, input adc_temp, input adc_press, output ready);
endinterface

// File: rtl/core/bpc_out_if.sv
interface bpc_out_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] fine_temp;
	logic signed [31:0] temp_centi;
	logic [31:0]        press_q24_8;
	logic               press_invalid;

	modport source(output valid, output fine_temp, output temp_centi,
		output press_q24_8, output press_invalid, input ready);
	modport sink(input valid, input fine_temp, input temp_centi,
		input press_q24_8, input press_invalid, output ready);
endinterface

// File: rtl/core/barometric_pressure_compensation.sv
// Throughput: one item per cycle; a stalled output holds every stage in place.
// Stages: 11 front stages, a 64-step restoring divider, 6 back stages.
// Reset: arst_n clears all valid bits and the calibration registers.
// The calibration registers keep their values until written again.
module barometric_pressure_compensation (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic [7:0]   cfg_index,
	input  logic [63:0]  cfg_data,
	bpc_in_if.sink       sample,
	bpc_out_if.source    result
);

	logic [47:0] cal_temp_q;
	logic [63:0] cal_press_a_q;
	logic [63:0] cal_press_b_q;
	logic [15:0] cal_press_c_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_temp_q    <= '0;
			cal_press_a_q <= '0;
			cal_press_b_q <= '0;
			cal_press_c_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				bpc_pkg::RegCalTemp:   cal_temp_q    <= cfg_data[47:0];
				bpc_pkg::RegCalPressA: cal_press_a_q <= cfg_data;
				bpc_pkg::RegCalPressB: cal_press_b_q <= cfg_data;
				bpc_pkg::RegCalPressC: cal_press_c_q <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	logic [15:0]        t1;
	logic signed [15:0] t2, t3;
	logic [15:0]        p1;
	logic signed [15:0] p2, p3, p4, p5, p6, p7, p8, p9;

	assign t1 = cal_temp_q[15:0];
	assign t2 = $signed(cal_temp_q[31:16]);
	assign t3 = $signed(cal_temp_q[47:32]);
	assign p1 = cal_press_a_q[15:0];
	assign p2 = $signed(cal_press_a_q[31:16]);
	assign p3 = $signed(cal_press_a_q[47:32]);
	assign p4 = $signed(cal_press_a_q[63:48]);
	assign p5 = $signed(cal_press_b_q[15:0]);
	assign p6 = $signed(cal_press_b_q[31:16]);
	assign p7 = $signed(cal_press_b_q[47:32]);
	assign p8 = $signed(cal_press_b_q[63:48]);
	assign p9 = $signed(cal_press_c_q);

	logic en;
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9, v_s10, v_s11;
	logic v_div;
	logic v_s12, v_s13, v_s14, v_s15, v_s16, v_s17;

	assign en           = ~v_s17 | result.ready;
	assign sample.ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			v_s3  <= 1'b0;
			v_s4  <= 1'b0;
			v_s5  <= 1'b0;
			v_s6  <= 1'b0;
			v_s7  <= 1'b0;
			v_s8  <= 1'b0;
			v_s9  <= 1'b0;
			v_s10 <= 1'b0;
			v_s11 <= 1'b0;
			v_s12 <= 1'b0;
			v_s13 <= 1'b0;
			v_s14 <= 1'b0;
			v_s15 <= 1'b0;
			v_s16 <= 1'b0;
			v_s17 <= 1'b0;
		end else if (en) begin
			v_s1  <= sample.valid;
			v_s2  <= v_s1;
			v_s3  <= v_s2;
			v_s4  <= v_s3;
			v_s5  <= v_s4;
			v_s6  <= v_s5;
			v_s7  <= v_s6;
			v_s8  <= v_s7;
			v_s9  <= v_s8;
			v_s10 <= v_s9;
			v_s11 <= v_s10;
			v_s12 <= v_div;
			v_s13 <= v_s12;
			v_s14 <= v_s13;
			v_s15 <= v_s14;
			v_s16 <= v_s15;
			v_s17 <= v_s16;
		end
	end

	// temperature path
	logic signed [17:0] d1_s1;
	logic signed [16:0] d2_s1;
	logic [20:0]        pr_s1, pr_s2, pr_s3, pr_s4, pr_s5, pr_s6, pr_s7, pr_s8;
	logic signed [33:0] m1_s2, sq_s2;
	logic signed [22:0] tv1_s3;
	logic signed [37:0] m2_s3;
	logic signed [31:0] fine_s4;
	logic signed [34:0] f5;

	localparam logic [20:0] PressFullLoc = bpc_pkg::PressFull;

	always_ff @(posedge clk) begin
		if (en) begin
			d1_s1  <= $signed(18'({1'b0, sample.adc_temp[19:3]}) - 18'({t1, 1'b0}));
			d2_s1  <= $signed(17'({1'b0, sample.adc_temp[19:4]}) - 17'({1'b0, t1}));
			pr_s1  <= PressFullLoc - 21'(sample.adc_press);
			m1_s2  <= d1_s1 * t2;
			sq_s2  <= d2_s1 * d2_s1;
			pr_s2  <= pr_s1;
			tv1_s3 <= 23'(m1_s2 >>> 11);
			m2_s3  <= $signed(sq_s2[33:12]) * t3;
			pr_s3  <= pr_s2;
			fine_s4 <= 32'(tv1_s3) + 32'(m2_s3 >>> 14);
			pr_s4  <= pr_s3;
		end
	end

	assign f5 = (35'(fine_s4) <<< 2) + 35'(fine_s4) + bpc_pkg::RoundT;

	// pressure path
	bpc_pkg::bpc_side_t side_s5, side_s6, side_s7, side_s8, side_s9, side_s10;
	bpc_pkg::bpc_side_t side_s11, side_div, side_s12, side_s13, side_s14;
	bpc_pkg::bpc_side_t side_s15, side_s16, side_s17;
	logic signed [31:0] a_s5;
	logic signed [63:0] aa_s6;
	logic signed [47:0] ap5_s6, ap2_s6, ap5_s7, ap2_s7;
	logic [63:0]        b1_s7, c1_s7, b_s8, a2_s8, x_s9, n0_s9;
	logic [63:0]        xp_s10, num_s10;
	logic signed [30:0] dv;
	logic [63:0]        ma_s11;
	logic [30:0]        mb_s11;
	logic [63:0]        quo;

	localparam logic [63:0] OneQ = 64'd1 << bpc_pkg::ShiftOne;

	assign dv = $signed(xp_s10[63:bpc_pkg::ShiftDiv]);

	always_ff @(posedge clk) begin
		if (en) begin
			side_s5.fine_temp  <= fine_s4;
			side_s5.temp_centi <= 32'(f5 >>> 8);
			side_s5.bad        <= 1'b0;
			side_s5.neg        <= 1'b0;
			a_s5   <= fine_s4 - bpc_pkg::OffsetFine;
			pr_s5  <= pr_s4;

			aa_s6  <= 64'(a_s5) * 64'(a_s5);
			ap5_s6 <= 48'(a_s5) * 48'(p5);
			ap2_s6 <= 48'(a_s5) * 48'(p2);
			pr_s6  <= pr_s5;
			side_s6 <= side_s5;

			b1_s7  <= bpc_pkg::mul64x16(aa_s6, 17'(p6));
			c1_s7  <= bpc_pkg::mul64x16(aa_s6, 17'(p3));
			ap5_s7 <= ap5_s6;
			ap2_s7 <= ap2_s6;
			pr_s7  <= pr_s6;
			side_s7 <= side_s6;

			b_s8   <= b1_s7 + (64'(ap5_s7) << 17) + (64'(p4) << 35);
			a2_s8  <= 64'($signed(c1_s7) >>> 8) + (64'(ap2_s7) << 12);
			pr_s8  <= pr_s7;
			side_s8 <= side_s7;

			x_s9   <= OneQ + a2_s8;
			n0_s9  <= (64'(pr_s8) << 31) - b_s8;
			side_s9 <= side_s8;

			xp_s10  <= bpc_pkg::mul64x16(x_s9, $signed({1'b0, p1}));
			num_s10 <= n0_s9 * bpc_pkg::ScaleDiv;
			side_s10 <= side_s9;

			ma_s11 <= num_s10[63] ? 64'd0 - num_s10 : num_s10;
			mb_s11 <= dv[30] ? 31'd0 - dv : dv;
			side_s11.fine_temp  <= side_s10.fine_temp;
			side_s11.temp_centi <= side_s10.temp_centi;
			side_s11.bad        <= (dv == '0);
			side_s11.neg        <= num_s10[63] ^ dv[30];
		end
	end

	bpc_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s11),
		.num       (ma_s11),
		.den       (mb_s11),
		.in_side   (side_s11),
		.out_valid (v_div),
		.quo       (quo),
		.out_side  (side_div)
	);

	logic [63:0] p_s12, p_s13, s_c;
	logic [63:0] sqlo_s13, pp8_s13, ss_s14, part_s14, m_s15, part_s15, sum_s16;
	logic [31:0] cross_s13;
	logic [31:0] press_s17;

	assign s_c = 64'($signed(p_s12) >>> 13);

	always_ff @(posedge clk) begin
		if (en) begin
			p_s12    <= side_div.neg ? 64'd0 - quo : quo;
			side_s12 <= side_div;

			sqlo_s13  <= 64'(s_c[31:0]) * 64'(s_c[31:0]);
			cross_s13 <= 32'(s_c[31:0] * s_c[63:32]);
			pp8_s13   <= bpc_pkg::mul64x16(p_s12, 17'(p8));
			p_s13     <= p_s12;
			side_s13  <= side_s12;

			ss_s14   <= sqlo_s13 + {cross_s13[30:0], 33'd0};
			part_s14 <= p_s13 + 64'($signed(pp8_s13) >>> 19);
			side_s14 <= side_s13;

			m_s15    <= bpc_pkg::mul64x16(ss_s14, 17'(p9));
			part_s15 <= part_s14;
			side_s15 <= side_s14;

			sum_s16  <= part_s15 + 64'($signed(m_s15) >>> 25);
			side_s16 <= side_s15;

			press_s17 <= side_s16.bad ? 32'd0 : sum_s16[39:8] + (32'(p7) << 4);
			side_s17  <= side_s16;
		end
	end

	assign result.valid         = v_s17;
	assign result.fine_temp     = side_s17.fine_temp;
	assign result.temp_centi    = side_s17.temp_centi;
	assign result.press_q24_8   = press_s17;
	assign result.press_invalid = side_s17.bad;

	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.press_invalid |-> result.press_q24_8 == 32'd0)
		else $error("pressure not forced to zero on zero divisor");

	a_centi: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> result.temp_centi ==
			32'(((35'(result.fine_temp) <<< 2) + 35'(result.fine_temp)
				+ bpc_pkg::RoundT) >>> 8))
		else $error("temp_centi does not match fine_temp");

	a_rise: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result.valid) |-> $past(en) && $past(v_s16))
		else $error("result valid without an advancing pipeline");

endmodule

// File: rtl/core/bpc_div.sv
module bpc_div (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                in_valid,
	input  logic [63:0]         num,
	input  logic [30:0]         den,
	input  bpc_pkg::bpc_side_t  in_side,
	output logic                out_valid,
	output logic [63:0]         quo,
	output bpc_pkg::bpc_side_t  out_side
);

	localparam int Steps = bpc_pkg::DivSteps;

	logic [30:0]        rem_s  [Steps];
	logic [63:0]        nq_s   [Steps];
	logic [30:0]        den_s  [Steps];
	bpc_pkg::bpc_side_t side_s [Steps];
	logic [Steps-1:0]   vld_s;

	for (genvar k = 0; k < Steps; k++) begin : g_step
		logic [30:0]        rem_c;
		logic [63:0]        nq_c;
		logic [30:0]        den_c;
		bpc_pkg::bpc_side_t side_c;
		logic               vld_c;
		logic [31:0]        trial;
		logic [31:0]        diff;
		logic               take;

		if (k == 0) begin : g_first
			assign rem_c  = '0;
			assign nq_c   = num;
			assign den_c  = den;
			assign side_c = in_side;
			assign vld_c  = in_valid;
		end else begin : g_next
			assign rem_c  = rem_s[k-1];
			assign nq_c   = nq_s[k-1];
			assign den_c  = den_s[k-1];
			assign side_c = side_s[k-1];
			assign vld_c  = vld_s[k-1];
		end

		assign trial = {rem_c, nq_c[63]};
		assign diff  = trial - {1'b0, den_c};
		assign take  = ~diff[31];

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k]  <= take ? diff[30:0] : trial[30:0];
				nq_s[k]   <= {nq_c[62:0], take};
				den_s[k]  <= den_c;
				side_s[k] <= side_c;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= vld_c;
			end
		end
	end

	assign out_valid = vld_s[Steps-1];
	assign quo       = nq_s[Steps-1];
	assign out_side  = side_s[Steps-1];

endmodule

// File: verif/tb.sv
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic signed [31:0] fine_temp;
		logic signed [31:0] temp_centi;
		logic [31:0]        press_q24_8;
		logic               press_invalid;
	} reading_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [7:0]  cfg_index;
	logic [63:0] cfg_data;

	bpc_in_if  sample ();
	bpc_out_if result ();

	barometric_pressure_compensation dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.sample    (sample.sink),
		.result    (result.source)
	);

	logic [47:0] cal_temp;
	logic [63:0] cal_press_a;
	logic [63:0] cal_press_b;
	logic [15:0] cal_press_c;

	reading_t expected_readings[$];
	int       mismatches = 0;
	int       send_idle_pct;
	int       recv_stall_pct;
	int       hold_off_req;
	int       hold_off_seen;
	int       hold_off_left;
	int       hold_off_len;

	always #1 clk = ~clk;

	function automatic reading_t compensate(input logic [19:0] at, input logic [19:0] ap);
		longint t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
		longint d1, d2, tv1, tv2, fine, tc, a, b, dv, p, num;
		reading_t r;
		t1 = longint'(cal_temp[15:0]);
		t2 = longint'($signed(cal_temp[31:16]));
		t3 = longint'($signed(cal_temp[47:32]));
		p1 = longint'(cal_press_a[15:0]);
		p2 = longint'($signed(cal_press_a[31:16]));
		p3 = longint'($signed(cal_press_a[47:32]));
		p4 = longint'($signed(cal_press_a[63:48]));
		p5 = longint'($signed(cal_press_b[15:0]));
		p6 = longint'($signed(cal_press_b[31:16]));
		p7 = longint'($signed(cal_press_b[47:32]));
		p8 = longint'($signed(cal_press_b[63:48]));
		p9 = longint'($signed(cal_press_c));
		d1 = longint'(at >> 3) - (t1 <<< 1);
		tv1 = (d1 * t2) >>> 11;
		d2 = longint'(at >> 4) - t1;
		tv2 = (((d2 * d2) >>> 12) * t3) >>> 14;
		fine = tv1 + tv2;
		tc = (fine * 64'sd5 + 64'sd128) >>> 8;
		a = fine - 64'sd128000;
		b = a * a * p6;
		b = b + ((a * p5) <<< 17);
		b = b + (p4 <<< 35);
		a = ((a * a * p3) >>> 8) + ((a * p2) <<< 12);
		dv = (((64'sd1 <<< 47) + a) * p1) >>> 33;
		r.fine_temp = fine[31:0];
		r.temp_centi = tc[31:0];
		if (dv == 0) begin
			r.press_q24_8 = '0;
			r.press_invalid = 1'b1;
		end else begin
			p = 64'sd1048576 - longint'(ap);
			num = ((p <<< 31) - b) * 64'sd3125;
			if (dv == -64'sd1)
				p = -num;
			else
				p = num / dv;
			a = (p9 * (p >>> 13) * (p >>> 13)) >>> 25;
			b = (p8 * p) >>> 19;
			p = ((p + a + b) >>> 8) + (p7 <<< 4);
			r.press_q24_8 = p[31:0];
			r.press_invalid = 1'b0;
		end
		return r;
	endfunction

	task automatic send_reading(input logic [19:0] at, input logic [19:0] ap);
		while ($urandom_range(99) < send_idle_pct) begin
			sample.valid <= 1'b0;
			@(posedge clk);
		end
		sample.valid <= 1'b1;
		sample.adc_temp <= at;
		sample.adc_press <= ap;
		@(negedge clk);
		while (!sample.ready)
			@(negedge clk);
		@(posedge clk);
		expected_readings.push_back(compensate(at, ap));
	endtask

	task automatic drain();
		sample.valid <= 1'b0;
		while (expected_readings.size() != 0)
			@(posedge clk);
		repeat (90) @(posedge clk);
	endtask

	task automatic write_reg(input logic [7:0] idx, input logic [63:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		case (idx)
			bpc_pkg::RegCalTemp:   cal_temp = data[47:0];
			bpc_pkg::RegCalPressA: cal_press_a = data;
			bpc_pkg::RegCalPressB: cal_press_b = data;
			bpc_pkg::RegCalPressC: cal_press_c = data[15:0];
			default: ;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic load_cal(input logic [63:0] ct, input logic [63:0] pa,
		input logic [63:0] pb, input logic [63:0] pc);
		drain();
		write_reg(bpc_pkg::RegCalTemp, ct);
		write_reg(bpc_pkg::RegCalPressA, pa);
		write_reg(bpc_pkg::RegCalPressB, pb);
		write_reg(bpc_pkg::RegCalPressC, pc);
	endtask

	function automatic logic [15:0] near(input logic [15:0] v);
		return v + 16'($urandom_range(400)) - 16'd200;
	endfunction

	task automatic load_typical();
		load_cal(64'({16'(-1000), near(16'd26435), near(16'd27504)}),
			{near(16'd2855), near(16'd3024), near(16'(-10685)), near(16'd36477)},
			{near(16'(-14600)), near(16'd15500), near(16'(-7)), near(16'd140)},
			{48'd0, near(16'd6000)});
	endtask

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	function automatic logic [19:0] adc_near(input int centre);
		return 20'(centre + $urandom_range(200000) - 100000);
	endfunction

	task automatic test_directed();
		send_reading(20'h00000, 20'h00000);
		send_reading(20'hfffff, 20'hfffff);
		load_typical();
		send_reading(20'd519888, 20'd415148);
		send_reading(20'h00000, 20'h00000);
		send_reading(20'hfffff, 20'hfffff);
		send_reading(20'h00000, 20'hfffff);
		send_reading(20'hfffff, 20'h00000);
		send_reading(20'h55555, 20'haaaaa);
		load_cal(64'({16'h7fff, 16'h7fff, 16'hffff}),
			{16'h7fff, 16'h7fff, 16'h7fff, 16'hffff},
			{16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff}, 64'h7fff);
		send_reading(20'h00000, 20'h00000);
		send_reading(20'hfffff, 20'hfffff);
		load_cal(64'({16'h8000, 16'h8000, 16'h0000}),
			{16'h8000, 16'h8000, 16'h8000, 16'h0001},
			{16'h8000, 16'h8000, 16'h8000, 16'h8000}, 64'h8000);
		send_reading(20'h00000, 20'hfffff);
		send_reading(20'hfffff, 20'h00000);
		// zero divisor: P1 cleared
		load_cal(64'({16'd26435, 16'd26435, 16'd27504}),
			{16'd2855, 16'd3024, 16'(-10685), 16'd0},
			{16'(-14600), 16'd15500, 16'(-7), 16'd140}, 64'd6000);
		send_reading(20'd519888, 20'd415148);
		send_reading(20'hfffff, 20'h00000);
		// register index out of range and wide data
		drain();
		write_reg(8'd4, rand64());
		write_reg(8'hff, rand64());
		write_reg(bpc_pkg::RegCalTemp,
			64'hffff_0000_0000_0000 | {16'd0, 16'(-1000), 16'd26435, 16'd27504});
		write_reg(bpc_pkg::RegCalPressC, 64'hffff_ffff_ffff_0000 | 64'd6000);
		send_reading(20'd519888, 20'd415148);
		send_reading(20'd1, 20'd1);
	endtask

	task automatic run_batch(input int n);
		for (int i = 0; i < n; i++) begin
			case ($urandom_range(9))
				0: send_reading(20'($urandom), 20'($urandom));
				1: send_reading($urandom_range(1) ? 20'hfffff : 20'h0,
					$urandom_range(1) ? 20'hfffff : 20'h0);
				default: send_reading(adc_near(519888), adc_near(415148));
			endcase
		end
	endtask

	task automatic test_random(input int idle_pct, input int stall_pct);
		send_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		for (int k = 0; k < 4; k++) begin
			case (k)
				0, 1: load_typical();
				2: load_cal(rand64(), rand64(), rand64(), rand64());
				default: load_cal(rand64(),
					{48'(rand64() >> 16), $urandom_range(1) ? 16'd0 : 16'd1},
					rand64(), rand64());
			endcase
			run_batch(100);
		end
	endtask

	task automatic test_backpressure();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		load_typical();
		hold_off_len = 300;
		hold_off_req++;
		run_batch(150);
		// pause until everything is out, then resume
		sample.valid <= 1'b0;
		while (expected_readings.size() != 0)
			@(posedge clk);
		run_batch(50);
	endtask

	always @(posedge clk) begin
		if (!arst_n) begin
			hold_off_seen <= 0;
			hold_off_left <= 0;
			result.ready <= 1'b0;
		end else if (hold_off_seen != hold_off_req) begin
			hold_off_seen <= hold_off_req;
			hold_off_left <= hold_off_len;
			result.ready <= 1'b0;
		end else if (hold_off_left > 0) begin
			hold_off_left <= hold_off_left - 1;
			result.ready <= 1'b0;
		end else begin
			result.ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	always @(negedge clk) begin
		reading_t want;
		reading_t got;
		if (arst_n && result.valid && result.ready) begin
			got = {result.fine_temp, result.temp_centi, result.press_q24_8,
				result.press_invalid};
			if (expected_readings.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected item: %h", got);
			end else begin
				want = expected_readings.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: fine %0d/%0d centi %0d/%0d press %h/%h inv %b/%b",
							want.fine_temp, got.fine_temp, want.temp_centi, got.temp_centi,
							want.press_q24_8, got.press_q24_8, want.press_invalid,
							got.press_invalid);
				end
			end
		end
	end

	initial begin
		#2000000;
		$display("== FAIL ==");
		$finish;
	end

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		sample.valid = 1'b0;
		sample.adc_temp = '0;
		sample.adc_press = '0;
		cal_temp = '0;
		cal_press_a = '0;
		cal_press_b = '0;
		cal_press_c = '0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_off_req = 0;
		hold_off_len = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random(0, 0);
		test_random(73, 0);
		test_random(0, 73);
		test_random(31, 31);
		test_backpressure();
		drain();
		if (mismatches == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end
endmodule

// File: filelist.f
rtl/core/bpc_pkg.sv
rtl/core/bpc_in_if.sv
rtl/core/bpc_out_if.sv
rtl/core/bpc_div.sv
rtl/core/barometric_pressure_compensation.sv
verif/tb.sv
